/* rtl/core/vpr_pkg.sv */
`default_nettype none
package vpr_pkg;

  localparam int VelW = 24;
  localparam int CountW = 17;
  localparam int MAX_PARTICLES = 65536;
  localparam int SumW = 40;
  localparam int SqSumW = 64;
  localparam int MeanSqW = 48;
  localparam int OrderW = 23;
  localparam int IdxW = 4;
  localparam int IterW = 7;

  localparam logic [OrderW-1:0] ONE_Q22 = 23'd4194304;

  // iteration counts of the shared sqrt and divide unit
  localparam int SqrtPLen = 30;
  localparam int SqrtFLen = 40;
  localparam int DivPLen = 52;
  localparam int DivSqLen = 64;
  localparam int DivFLen = 40;

  // final division slots and last indices of the multiply and unit loops
  localparam logic [IdxW-1:0] FD_MEAN_SQ = 4'd0;
  localparam logic [IdxW-1:0] FD_ORDER = 4'd4;
  localparam logic [IdxW-1:0] MUL_P_LAST = 4'd2;
  localparam logic [IdxW-1:0] MUL_F_LAST = 4'd8;
  localparam logic [IdxW-1:0] UNIT_LAST = 4'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_P,
    OP_MUL_F,
    OP_ACC_P,
    OP_ACLR,
    OP_SQRT_LOAD_F,
    OP_SQRT_STEP,
    OP_DIV_LOAD_P,
    OP_DIV_LOAD_F,
    OP_DIV_STEP,
    OP_UNIT_ACC,
    OP_FSTORE,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL,
    S_FLUSH,
    S_ACC,
    S_SQRT,
    S_DIV_LOAD,
    S_DIV,
    S_UNIT,
    S_FINIT,
    S_FMUL,
    S_FFLUSH,
    S_FSQL,
    S_FSQRT,
    S_FDIV_LOAD,
    S_FDIV,
    S_FSTORE,
    S_EMIT
  } state_t;

  typedef struct packed {
    dp_op_t          op;
    logic [IdxW-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic zero;
    logic out_full;
  } dp_stat_t;

  function automatic logic [IterW-1:0] div_len_f(input logic [IdxW-1:0] idx);
    div_len_f = (idx == FD_MEAN_SQ) ? IterW'(DivSqLen) : IterW'(DivFLen);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/vpr_if.sv */
`default_nettype none
interface vpr_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [vpr_pkg::VelW-1:0] vel_x;
  logic signed [vpr_pkg::VelW-1:0] vel_y;
  logic signed [vpr_pkg::VelW-1:0] vel_z;
  logic                            last_particle;

  modport source (output valid, vel_x, vel_y, vel_z, last_particle, input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, last_particle, output ready);
endinterface

interface vpr_out_if;
  logic                               valid;
  logic                               ready;
  logic        [vpr_pkg::MeanSqW-1:0] mean_speed_sq;
  logic signed [vpr_pkg::VelW-1:0]    mean_vel_x;
  logic signed [vpr_pkg::VelW-1:0]    mean_vel_y;
  logic signed [vpr_pkg::VelW-1:0]    mean_vel_z;
  logic        [vpr_pkg::OrderW-1:0]  order_value;
  logic        [vpr_pkg::CountW-1:0]  particle_count;
  logic                               zero_speed_seen;

  modport source (output valid, mean_speed_sq, mean_vel_x, mean_vel_y, mean_vel_z,
                  order_value, particle_count, zero_speed_seen, input ready);
  modport sink (input valid, mean_speed_sq, mean_vel_x, mean_vel_y, mean_vel_z,
                order_value, particle_count, zero_speed_seen, output ready);
endinterface
`default_nettype wire

/* rtl/core/vpr_ctrl.sv */
`default_nettype none
module vpr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  vpr_pkg::dp_stat_t stat,
  output vpr_pkg::dp_cmd_t  cmd
);
  import vpr_pkg::*;

  state_t            state, state_next;
  logic [IdxW-1:0]   idx, idx_next;
  logic [IterW-1:0]  iter, iter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      iter  <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      iter  <= iter_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    iter_next  = iter;
    cmd.op     = OP_NONE;
    cmd.idx    = idx;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          idx_next   = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op = OP_MUL_P;
        if (idx == MUL_P_LAST) state_next = S_FLUSH;
        else idx_next = idx + 1'b1;
      end
      S_FLUSH: begin
        // full frame drops the particle
        if (stat.full) state_next = stat.last ? S_FINIT : S_IDLE;
        else state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op    = OP_ACC_P;
        iter_next = '0;
        if (stat.zero) state_next = stat.last ? S_FINIT : S_IDLE;
        else state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (iter == IterW'(SqrtPLen - 1)) begin
          idx_next   = '0;
          state_next = S_DIV_LOAD;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      S_DIV_LOAD: begin
        cmd.op     = OP_DIV_LOAD_P;
        iter_next  = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (iter == IterW'(DivPLen - 1)) state_next = S_UNIT;
        else iter_next = iter + 1'b1;
      end
      S_UNIT: begin
        cmd.op = OP_UNIT_ACC;
        if (idx == UNIT_LAST) begin
          state_next = stat.last ? S_FINIT : S_IDLE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_DIV_LOAD;
        end
      end
      S_FINIT: begin
        cmd.op     = OP_ACLR;
        idx_next   = '0;
        state_next = S_FMUL;
      end
      S_FMUL: begin
        cmd.op = OP_MUL_F;
        if (idx == MUL_F_LAST) state_next = S_FFLUSH;
        else idx_next = idx + 1'b1;
      end
      S_FFLUSH: state_next = S_FSQL;
      S_FSQL: begin
        cmd.op     = OP_SQRT_LOAD_F;
        iter_next  = '0;
        state_next = S_FSQRT;
      end
      S_FSQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (iter == IterW'(SqrtFLen - 1)) begin
          idx_next   = '0;
          state_next = S_FDIV_LOAD;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      S_FDIV_LOAD: begin
        cmd.op     = OP_DIV_LOAD_F;
        iter_next  = '0;
        state_next = S_FDIV;
      end
      S_FDIV: begin
        cmd.op = OP_DIV_STEP;
        if (iter == div_len_f(idx) - 1'b1) state_next = S_FSTORE;
        else iter_next = iter + 1'b1;
      end
      S_FSTORE: begin
        cmd.op = OP_FSTORE;
        if (idx == FD_ORDER) begin
          state_next = S_EMIT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_FDIV_LOAD;
        end
      end
      S_EMIT: begin
        if (!stat.out_full) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/vpr_dp.sv */
`default_nettype none
module vpr_dp (
  input  logic              clk,
  input  logic              rst,
  input  vpr_pkg::dp_cmd_t  cmd,
  output vpr_pkg::dp_stat_t stat,
  vpr_in_if.sink            particle,
  vpr_out_if.source         result
);
  import vpr_pkg::*;

  logic signed [VelW-1:0]   vel [3];
  logic                     last_q;
  logic [VelW-1:0]          vmag [3];
  logic [SqSumW-1:0]        speed_sq_sum;
  logic signed [SumW-1:0]   vel_sum [3];
  logic signed [SumW-1:0]   unit_sum [3];
  logic [SumW-1:0]          vsmag [3];
  logic [SumW-1:0]          umag [3];
  logic [CountW-1:0]        count;
  logic                     zflag;
  logic [CountW-1:0]        n_div;

  // multiplier
  logic [VelW-1:0]          mul_a, mul_b;
  logic [1:0]               mul_sh;
  logic [2*VelW-1:0]        prod;
  logic [1:0]               prod_sh;
  logic                     prod_vld;
  logic [79:0]              acc;
  logic [79:0]              prod_ext;
  logic [1:0]               c_sel;
  logic [1:0]               t_sel;

  // sqrt unit
  logic [79:0]              rad;
  logic [41:0]              srem;
  logic [39:0]              root;
  logic [41:0]              srem2, strial;
  logic                     sge;

  // divide unit
  logic [63:0]              dvd;
  logic [29:0]              drem;
  logic [29:0]              dvs;
  logic [63:0]              quo;
  logic [30:0]              dr2, ddiff;
  logic                     dge;
  logic [OrderW-1:0]        qclamp;
  logic [1:0]               fc;

  // results
  logic [MeanSqW-1:0]       res_msq;
  logic signed [VelW-1:0]   res_mv [3];
  logic [OrderW-1:0]        res_ord;
  logic                     out_vld;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vmag[i]  = vel[i][VelW-1] ? VelW'(-vel[i]) : vel[i];
      vsmag[i] = vel_sum[i][SumW-1] ? SumW'(-vel_sum[i]) : vel_sum[i];
      umag[i]  = unit_sum[i][SumW-1] ? SumW'(-unit_sum[i]) : unit_sum[i];
    end
    n_div = (count == '0) ? CountW'(1) : count;
  end

  // multiplier operand select; final terms split each unit sum into 20-bit halves
  always_comb begin
    c_sel = 2'd0;
    t_sel = 2'd0;
    case (cmd.idx)
      4'd0: begin c_sel = 2'd0; t_sel = 2'd0; end
      4'd1: begin c_sel = 2'd0; t_sel = 2'd1; end
      4'd2: begin c_sel = 2'd0; t_sel = 2'd2; end
      4'd3: begin c_sel = 2'd1; t_sel = 2'd0; end
      4'd4: begin c_sel = 2'd1; t_sel = 2'd1; end
      4'd5: begin c_sel = 2'd1; t_sel = 2'd2; end
      4'd6: begin c_sel = 2'd2; t_sel = 2'd0; end
      4'd7: begin c_sel = 2'd2; t_sel = 2'd1; end
      4'd8: begin c_sel = 2'd2; t_sel = 2'd2; end
      default: begin c_sel = 2'd0; t_sel = 2'd0; end
    endcase
    if (cmd.op == OP_MUL_F) begin
      mul_sh = t_sel;
      case (t_sel)
        2'd0: begin
          mul_a = {4'b0, umag[c_sel][19:0]};
          mul_b = {4'b0, umag[c_sel][19:0]};
        end
        2'd1: begin
          mul_a = {4'b0, umag[c_sel][39:20]};
          mul_b = {4'b0, umag[c_sel][19:0]};
        end
        default: begin
          mul_a = {4'b0, umag[c_sel][39:20]};
          mul_b = {4'b0, umag[c_sel][39:20]};
        end
      endcase
    end else begin
      mul_sh = 2'd0;
      mul_a  = vmag[cmd.idx[1:0]];
      mul_b  = vmag[cmd.idx[1:0]];
    end
  end

  always_comb begin
    case (prod_sh)
      2'd0:    prod_ext = {32'b0, prod};
      2'd1:    prod_ext = {11'b0, prod, 21'b0};
      default: prod_ext = {prod[39:0], 40'b0};
    endcase
  end

  // one root bit per step
  assign srem2  = {srem[39:0], rad[79:78]};
  assign strial = {root, 2'b01};
  assign sge    = (srem2 >= strial);

  // one quotient bit per step
  assign dr2   = {drem, dvd[63]};
  assign dge   = (dr2 >= {1'b0, dvs});
  assign ddiff = dr2 - {1'b0, dvs};

  assign qclamp = (quo > {41'b0, ONE_Q22}) ? ONE_Q22 : quo[OrderW-1:0];
  assign fc     = 2'(cmd.idx - 4'd1);

  always_ff @(posedge clk) begin
    prod     <= mul_a * mul_b;
    prod_sh  <= mul_sh;
    prod_vld <= (cmd.op == OP_MUL_P) || (cmd.op == OP_MUL_F);
    if (prod_vld) acc <= acc + prod_ext;

    case (cmd.op)
      OP_LOAD: begin
        vel[0] <= particle.vel_x;
        vel[1] <= particle.vel_y;
        vel[2] <= particle.vel_z;
        last_q <= particle.last_particle;
        acc    <= '0;
      end
      OP_ACLR: acc <= '0;
      OP_ACC_P: begin
        speed_sq_sum <= speed_sq_sum + acc[SqSumW-1:0];
        for (int i = 0; i < 3; i++) begin
          vel_sum[i] <= vel_sum[i] + SumW'(vel[i]);
        end
        count <= count + 1'b1;
        if (acc == '0) zflag <= 1'b1;
        // speed = isqrt(s * 2^12), radicand left aligned for 30 steps
        rad  <= {acc[47:0], 32'b0};
        srem <= '0;
        root <= '0;
      end
      OP_SQRT_LOAD_F: begin
        rad  <= acc;
        srem <= '0;
        root <= '0;
      end
      OP_SQRT_STEP: begin
        rad <= {rad[77:0], 2'b00};
        if (sge) begin
          srem <= srem2 - strial;
          root <= {root[38:0], 1'b1};
        end else begin
          srem <= srem2;
          root <= {root[38:0], 1'b0};
        end
      end
      OP_DIV_LOAD_P: begin
        // |v| * 2^28, aligned for 52 steps
        dvd  <= {vmag[cmd.idx[1:0]], 40'b0};
        dvs  <= root[29:0];
        drem <= '0;
        quo  <= '0;
      end
      OP_DIV_LOAD_F: begin
        case (cmd.idx)
          FD_MEAN_SQ: dvd <= speed_sq_sum;
          FD_ORDER:   dvd <= {root, 24'b0};
          default:    dvd <= {vsmag[fc], 24'b0};
        endcase
        dvs  <= {13'b0, n_div};
        drem <= '0;
        quo  <= '0;
      end
      OP_DIV_STEP: begin
        dvd <= {dvd[62:0], 1'b0};
        if (dge) begin
          drem <= ddiff[29:0];
          quo  <= {quo[62:0], 1'b1};
        end else begin
          drem <= dr2[29:0];
          quo  <= {quo[62:0], 1'b0};
        end
      end
      OP_UNIT_ACC: begin
        if (vel[cmd.idx[1:0]][VelW-1]) begin
          unit_sum[cmd.idx[1:0]] <= unit_sum[cmd.idx[1:0]] - SumW'(qclamp);
        end else begin
          unit_sum[cmd.idx[1:0]] <= unit_sum[cmd.idx[1:0]] + SumW'(qclamp);
        end
      end
      OP_FSTORE: begin
        case (cmd.idx)
          FD_MEAN_SQ: res_msq <= quo[MeanSqW-1:0];
          FD_ORDER:   res_ord <= qclamp;
          default: begin
            res_mv[fc] <= vel_sum[fc][SumW-1] ? VelW'(-quo[VelW-1:0]) : quo[VelW-1:0];
          end
        endcase
      end
      OP_EMIT: begin
        result.mean_speed_sq   <= res_msq;
        result.mean_vel_x      <= res_mv[0];
        result.mean_vel_y      <= res_mv[1];
        result.mean_vel_z      <= res_mv[2];
        result.order_value     <= res_ord;
        result.particle_count  <= count;
        result.zero_speed_seen <= zflag;
      end
      default: ;
    endcase

    if (rst || cmd.op == OP_EMIT) begin
      speed_sq_sum <= '0;
      for (int i = 0; i < 3; i++) begin
        vel_sum[i]  <= '0;
        unit_sum[i] <= '0;
      end
      count <= '0;
      zflag <= 1'b0;
    end
    if (rst) prod_vld <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  assign result.valid  = out_vld;
  assign stat.full     = (count == CountW'(MAX_PARTICLES));
  assign stat.last     = last_q;
  assign stat.zero     = (acc == '0);
  assign stat.out_full = out_vld;

endmodule
`default_nettype wire

/* rtl/core/velocity_polarization_reduce.sv */
// Polarization order parameter over a stream of particle velocities.
// particle: sink channel, one beat per particle (vel_x/y/z signed Q7.16,
//   last_particle closes the frame). result: source channel, one beat per
//   frame with the means, the polarization, the count and the zero flag.
// Both channels move a beat when valid and ready are high at a clock edge.
// Each particle runs on one shared iterative unit: three squares on a 24x24
// multiplier, a 30-step square root for the speed and three 52-step
// divisions for the unit vector; a particle of zero speed skips the root
// and the divisions, and one past a full frame is dropped after its squares.
// The last particle then adds nine partial products, a 40-step root and
// five divisions by the count (64 steps, then four of 40). particle.ready
// is high only while the block waits for a beat.
// The finished frame sits in an output register, so the next frame starts
// while the receiver stalls; a second result waits until that register is
// taken. Synchronous reset clears all sums, the count and the output valid.
`default_nettype none
module velocity_polarization_reduce (
  input  logic      clk,
  input  logic      rst,
  vpr_in_if.sink    particle,
  vpr_out_if.source result
);
  import vpr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     ready;

  vpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (particle.valid),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vpr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .particle (particle),
    .result   (result)
  );

  assign particle.ready = ready;

endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
module tb;
  import vpr_pkg::*;

  typedef struct packed {
    logic signed [VelW-1:0] vx;
    logic signed [VelW-1:0] vy;
    logic signed [VelW-1:0] vz;
    logic                   last;
  } particle_t;

  typedef struct packed {
    logic        [MeanSqW-1:0] msq;
    logic signed [VelW-1:0]    mx;
    logic signed [VelW-1:0]    my;
    logic signed [VelW-1:0]    mz;
    logic        [OrderW-1:0]  order;
    logic        [CountW-1:0]  count;
    logic                      zero;
  } frame_res_t;

  typedef struct {
    particle_t  p;
    bit         typed;
    frame_res_t r;
  } stim_row_t;

  localparam int CycleLimit = 4000000;
  localparam int HoldStart = 30000;
  localparam int HoldLen = 8000;
  localparam int DrainWait = 500;

  logic clk;
  logic rst;
  int   errors = 0;
  int   cycles = 0;

  vpr_in_if  particle ();
  vpr_out_if result ();

  velocity_polarization_reduce uut (
    .clk     (clk),
    .rst     (rst),
    .particle(particle.sink),
    .result  (result.source)
  );

  // frame accumulators of the predictor
  logic [63:0]        acc_speed_sq;
  logic signed [63:0] acc_vel_x, acc_vel_y, acc_vel_z;
  logic signed [63:0] acc_unit_x, acc_unit_y, acc_unit_z;
  int                 acc_count;
  logic               acc_zero;

  frame_res_t frames_due[$];
  bit         beat_typed[$];
  frame_res_t beat_res[$];

  int burst_left = 0;

  // directed frames: typed expectations where the answer is plain
  stim_row_t directed_rows[] = '{
    '{'{24'sd65536, 24'sd0, 24'sd0, 1'b1}, 1'b1,
      '{48'h1_0000_0000, 24'sd65536, 24'sd0, 24'sd0, ONE_Q22, 17'd1, 1'b0}},
    '{'{24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b1,
      '{48'd0, 24'sd0, 24'sd0, 24'sd0, 23'd0, 17'd1, 1'b1}},
    '{'{-24'sd8388608, 24'sd0, 24'sd0, 1'b1}, 1'b1,
      '{48'h4000_0000_0000, -24'sd8388608, 24'sd0, 24'sd0, ONE_Q22, 17'd1, 1'b0}},
    '{'{24'sd0, 24'sd8388607, 24'sd0, 1'b1}, 1'b1,
      '{48'd70368727400449, 24'sd0, 24'sd8388607, 24'sd0, ONE_Q22, 17'd1, 1'b0}},
    '{'{24'sd0, 24'sd0, -24'sd1, 1'b1}, 1'b1,
      '{48'd1, 24'sd0, 24'sd0, -24'sd1, ONE_Q22, 17'd1, 1'b0}},
    '{'{24'sd8388607, 24'sd8388607, 24'sd8388607, 1'b0}, 1'b0, '0},
    '{'{-24'sd8388608, -24'sd8388608, -24'sd8388608, 1'b0}, 1'b0, '0},
    '{'{24'sd0, 24'sd0, 24'sd0, 1'b0}, 1'b0, '0},
    '{'{24'sd1, -24'sd1, 24'sd1, 1'b1}, 1'b0, '0},
    '{'{-24'sd8388608, 24'sd8388607, 24'sd0, 1'b0}, 1'b0, '0},
    '{'{24'sd123456, -24'sd7654321, 24'sd42, 1'b1}, 1'b0, '0},
    '{'{24'sd1, 24'sd0, 24'sd0, 1'b0}, 1'b0, '0},
    '{'{-24'sd1, 24'sd0, 24'sd0, 1'b1}, 1'b0, '0},
    '{'{24'sd0, 24'sd0, 24'sd0, 1'b0}, 1'b0, '0},
    '{'{24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b0, '0},
    '{'{24'sd5, 24'sd8388607, -24'sd3, 1'b0}, 1'b0, '0},
    '{'{24'sd0, -24'sd8388608, 24'sd65536, 1'b1}, 1'b0, '0}
  };

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] cc;
    r = '0;
    for (int b = 62; b >= 0; b--) begin
      c = r | (64'd1 << b);
      cc = {64'd0, c} * {64'd0, c};
      if (cc <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] unit_part(logic signed [63:0] v, logic [63:0] speed);
    logic [63:0] q;
    q = (mag64(v) << 28) / speed;
    if (q > 64'(ONE_Q22)) q = 64'(ONE_Q22);
    return v < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [VelW-1:0] mean_trunc(logic signed [63:0] s, int n);
    logic [63:0] q;
    q = mag64(s) / 64'(n);
    return s < 0 ? VelW'(-$signed(q)) : VelW'(q);
  endfunction

  function automatic void clear_frame();
    acc_speed_sq = '0;
    acc_vel_x = '0;
    acc_vel_y = '0;
    acc_vel_z = '0;
    acc_unit_x = '0;
    acc_unit_y = '0;
    acc_unit_z = '0;
    acc_count = 0;
    acc_zero = 1'b0;
  endfunction

  // returns 1 and fills res when the beat closes a frame
  function automatic bit accumulate_particle(particle_t p, output frame_res_t res);
    logic signed [63:0] vx, vy, vz;
    logic [63:0]        s, speed, pol, ux, uy, uz;
    logic [127:0]       wsum;
    int                 n;
    vx = 64'(p.vx);
    vy = 64'(p.vy);
    vz = 64'(p.vz);
    res = '0;
    if (acc_count < MAX_PARTICLES) begin
      s = mag64(vx) * mag64(vx) + mag64(vy) * mag64(vy) + mag64(vz) * mag64(vz);
      acc_speed_sq += s;
      acc_vel_x += vx;
      acc_vel_y += vy;
      acc_vel_z += vz;
      if (s == 0) begin
        acc_zero = 1'b1;
      end else begin
        speed = floor_root({52'd0, s, 12'd0});
        acc_unit_x += unit_part(vx, speed);
        acc_unit_y += unit_part(vy, speed);
        acc_unit_z += unit_part(vz, speed);
      end
      acc_count++;
    end
    if (!p.last) return 0;
    n = acc_count == 0 ? 1 : acc_count;
    ux = mag64(acc_unit_x);
    uy = mag64(acc_unit_y);
    uz = mag64(acc_unit_z);
    wsum = {64'd0, ux} * {64'd0, ux} + {64'd0, uy} * {64'd0, uy} + {64'd0, uz} * {64'd0, uz};
    pol = floor_root(wsum) / 64'(n);
    if (pol > 64'(ONE_Q22)) pol = 64'(ONE_Q22);
    res.msq = MeanSqW'(acc_speed_sq / 64'(n));
    res.mx = mean_trunc(acc_vel_x, n);
    res.my = mean_trunc(acc_vel_y, n);
    res.mz = mean_trunc(acc_vel_z, n);
    res.order = OrderW'(pol);
    res.count = CountW'(acc_count);
    res.zero = acc_zero;
    clear_frame();
    return 1;
  endfunction

  function automatic logic signed [VelW-1:0] rand_vel();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0: return '0;
      1: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      2: return $urandom_range(0, 1) ? VelW'($urandom_range(0, 255))
                                     : -VelW'($urandom_range(0, 255));
      default: return VelW'($urandom);
    endcase
  endfunction

  function automatic particle_t rand_particle(bit last);
    particle_t p;
    p.vx = rand_vel();
    p.vy = rand_vel();
    p.vz = rand_vel();
    p.last = last;
    return p;
  endfunction

  task automatic send_particle(particle_t p, bit typed, frame_res_t r);
    int gap;
    beat_typed.push_back(typed);
    beat_res.push_back(r);
    particle.valid <= 1'b1;
    particle.vel_x <= p.vx;
    particle.vel_y <= p.vy;
    particle.vel_z <= p.vz;
    particle.last_particle <= p.last;
    @(posedge clk);
    while (!particle.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        particle.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    // let the predictor take the last accepted beat first
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // predictor runs on every accepted particle beat
  always @(posedge clk) begin
    frame_res_t res;
    bit         typed;
    frame_res_t typed_res;
    if (!rst && particle.valid && particle.ready) begin
      typed = beat_typed.pop_front();
      typed_res = beat_res.pop_front();
      if (accumulate_particle(particle_t'({particle.vel_x, particle.vel_y, particle.vel_z,
                                           particle.last_particle}), res))
        frames_due.push_back(typed ? typed_res : res);
    end
  end

  always @(posedge clk) begin
    frame_res_t want;
    if (!rst && result.valid && result.ready) begin
      if (frames_due.size() == 0) begin
        $error("result beat with no frame outstanding");
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (result.mean_speed_sq !== want.msq) begin
          $error("mean_speed_sq: expected %0d, got %0d", want.msq, result.mean_speed_sq);
          errors++;
        end
        if (result.mean_vel_x !== want.mx) begin
          $error("mean_vel_x: expected %0d, got %0d", want.mx, result.mean_vel_x);
          errors++;
        end
        if (result.mean_vel_y !== want.my) begin
          $error("mean_vel_y: expected %0d, got %0d", want.my, result.mean_vel_y);
          errors++;
        end
        if (result.mean_vel_z !== want.mz) begin
          $error("mean_vel_z: expected %0d, got %0d", want.mz, result.mean_vel_z);
          errors++;
        end
        if (result.order_value !== want.order) begin
          $error("order_value: expected %0d, got %0d", want.order, result.order_value);
          errors++;
        end
        if (result.particle_count !== want.count) begin
          $error("particle_count: expected %0d, got %0d", want.count, result.particle_count);
          errors++;
        end
        if (result.zero_speed_seen !== want.zero) begin
          $error("zero_speed_seen: expected %0d, got %0d", want.zero, result.zero_speed_seen);
          errors++;
        end
      end
    end
  end

  // receiver: stall mode redrawn among always ready, random and sparse, one long hold-off
  initial begin
    int rx_cycle;
    int mode;
    rx_cycle = 0;
    mode = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 64 == 0) mode = $urandom_range(0, 2);
      if (rx_cycle >= HoldStart && rx_cycle < HoldStart + HoldLen)
        result.ready <= 1'b0;
      else if (mode == 0)
        result.ready <= 1'b1;
      else if (mode == 1)
        result.ready <= 1'($urandom_range(0, 1));
      else
        result.ready <= $urandom_range(0, 7) == 0;
    end
  end

  initial begin
    int sent;
    int frame_len;
    particle_t p;
    clear_frame();
    rst <= 1'b1;
    particle.valid <= 1'b0;
    particle.vel_x <= '0;
    particle.vel_y <= '0;
    particle.vel_z <= '0;
    particle.last_particle <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_particle(directed_rows[i].p, directed_rows[i].typed, directed_rows[i].r);

    sent = 0;
    while (sent < 1150) begin
      frame_len = $urandom_range(0, 7) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 12);
      for (int k = 0; k < frame_len; k++) begin
        p = rand_particle(k == frame_len - 1);
        send_particle(p, 1'b0, '0);
        sent++;
      end
    end

    // sender pauses until every frame is out
    particle.valid <= 1'b0;
    wait_drained();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/vpr_pkg.sv
rtl/core/vpr_if.sv
rtl/core/vpr_ctrl.sv
rtl/core/vpr_dp.sv
rtl/core/velocity_polarization_reduce.sv
dv/tb.sv
